// ===== rtl/core/tptok_pkg.sv =====
// Shared types, codes and byte classification for the UTF-8 pre-tokeniser.
package tptok_pkg;

	localparam logic [2:0] KIND_WORD  = 3'd0;
	localparam logic [2:0] KIND_CLOSE = 3'd1;
	localparam logic [2:0] KIND_PUNCT = 3'd2;
	localparam logic [2:0] KIND_MB    = 3'd3;
	localparam logic [2:0] KIND_UNK   = 3'd4;

	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_LEAD,
		CLS_BADHI,
		CLS_ALNUM,
		CLS_OTHER
	} byte_cls_t;

	typedef enum logic [2:0] {
		SRC_CLOSE,
		SRC_UNK,
		SRC_WORD,
		SRC_PUNCT,
		SRC_HELD,
		SRC_LAST
	} emit_src_t;

	typedef struct packed {
		logic      load;
		logic      emit;
		emit_src_t src;
		logic      pop;
		logic      requeue;
		logic      hold_byte;
		logic      start_char;
		logic      clr_held;
		logic      set_word;
		logic      clr_word;
		logic      idx_clr;
		logic      idx_inc;
		logic      flush;
	} dp_cmd_t;

	typedef struct packed {
		byte_cls_t head_cls;
		logic      pending;
		logic      complete;
		logic      last;
		logic      qlen_one;
		logic      word_open;
		logic      idx_lt;
		logic      eot;
		logic      out_free;
	} dp_status_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if ((b & 8'hE0) == 8'hC0)
			len = 3'd2;
		else if ((b & 8'hF0) == 8'hE0)
			len = 3'd3;
		else if ((b & 8'hF8) == 8'hF0)
			len = 3'd4;
		return len;
	endfunction

	function automatic byte_cls_t classify(input logic [7:0] b);
		byte_cls_t c;
		if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))
			c = CLS_SPACE;
		else if (b[7])
			c = (lead_len(b) != 3'd0) ? CLS_LEAD : CLS_BADHI;
		else if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
				(b >= 8'h41 && b <= 8'h5A))
			c = CLS_ALNUM;
		else
			c = CLS_OTHER;
		return c;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
	endfunction

endpackage

// ===== rtl/core/tptok_dp.sv =====
// Datapath: byte queue, held character bytes, word flag and the result registers.
module tptok_dp import tptok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	input  dp_cmd_t    cmd,
	output dp_status_t st,
	output logic [2:0] event_kind,
	output logic [7:0] out_byte,
	output logic       char_final,
	output logic       run_final,
	output logic       text_final,
	output logic       out_valid,
	input  logic       out_stall
);

	logic [7:0] q_q [3];
	logic [1:0] qlen_q;
	logic       eot_q;
	logic [7:0] held_q [3];
	logic [1:0] hc_q;
	logic [2:0] exp_q;
	logic       word_q;
	logic [1:0] idx_q;

	logic [2:0] pend_kind_q;
	logic [7:0] pend_byte_q;
	logic       pend_cf_q;
	logic       pend_valid_q;

	logic [2:0] kind_q;
	logic [7:0] byte_q;
	logic       cf_q;
	logic       rf_q;
	logic       tf_q;
	logic       ovalid_q;

	logic [7:0] head;
	logic [7:0] held_rd;
	logic [2:0] r_kind;
	logic [7:0] r_byte;
	logic       r_cf;
	logic       out_free;

	assign head     = q_q[0];
	assign held_rd  = (idx_q == 2'd3) ? 8'h00 : held_q[idx_q];
	assign out_free = !ovalid_q || !out_stall;

	assign st.head_cls  = classify(head);
	assign st.pending   = (exp_q != 3'd0);
	assign st.complete  = ({1'b0, hc_q} + 3'd1) >= exp_q;
	assign st.last      = eot_q && (qlen_q == 2'd1);
	assign st.qlen_one  = (qlen_q == 2'd1);
	assign st.word_open = word_q;
	assign st.idx_lt    = idx_q < hc_q;
	assign st.eot       = eot_q;
	assign st.out_free  = out_free;

	always_comb begin
		r_kind = KIND_CLOSE;
		r_byte = 8'h00;
		r_cf   = 1'b0;
		case (cmd.src)
			SRC_CLOSE: r_kind = KIND_CLOSE;
			SRC_UNK:   r_kind = KIND_UNK;
			SRC_WORD: begin
				r_kind = KIND_WORD;
				r_byte = to_lower(head);
			end
			SRC_PUNCT: begin
				r_kind = KIND_PUNCT;
				r_byte = head;
			end
			SRC_HELD: begin
				r_kind = KIND_MB;
				r_byte = held_rd;
			end
			SRC_LAST: begin
				r_kind = KIND_MB;
				r_byte = head;
				r_cf   = 1'b1;
			end
			default: r_kind = KIND_CLOSE;
		endcase
	end

	// Payload storage: queue, held bytes and result payloads
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q[0] <= data_byte;
			eot_q  <= end_of_text;
		end else if (cmd.requeue) begin
			// truncated character: bytes after the lead, then the current byte
			case (hc_q)
				2'd2: begin
					q_q[0] <= held_q[1];
					q_q[1] <= head;
				end
				2'd3: begin
					q_q[0] <= held_q[1];
					q_q[1] <= held_q[2];
					q_q[2] <= head;
				end
				default: q_q[0] <= head;
			endcase
		end else if (cmd.pop) begin
			q_q[0] <= q_q[1];
			q_q[1] <= q_q[2];
		end
		if (cmd.start_char)
			held_q[0] <= head;
		else if (cmd.hold_byte && hc_q != 2'd3)
			held_q[hc_q] <= head;
		if (cmd.emit) begin
			pend_kind_q <= r_kind;
			pend_byte_q <= r_byte;
			pend_cf_q   <= r_cf;
		end
		if ((cmd.emit || cmd.flush) && pend_valid_q) begin
			kind_q <= pend_kind_q;
			byte_q <= pend_byte_q;
			cf_q   <= pend_cf_q;
			rf_q   <= cmd.flush;
			tf_q   <= eot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q       <= 2'd0;
			hc_q         <= 2'd0;
			exp_q        <= 3'd0;
			word_q       <= 1'b0;
			idx_q        <= 2'd0;
			pend_valid_q <= 1'b0;
			ovalid_q     <= 1'b0;
		end else begin
			if (cmd.load)
				qlen_q <= 2'd1;
			else if (cmd.requeue)
				qlen_q <= hc_q;
			else if (cmd.pop)
				qlen_q <= qlen_q - 2'd1;

			if (cmd.start_char) begin
				hc_q  <= 2'd1;
				exp_q <= lead_len(head);
			end else if (cmd.hold_byte) begin
				hc_q <= hc_q + 2'd1;
			end else if (cmd.clr_held) begin
				hc_q  <= 2'd0;
				exp_q <= 3'd0;
			end

			if (cmd.set_word)
				word_q <= 1'b1;
			else if (cmd.clr_word)
				word_q <= 1'b0;

			if (cmd.idx_clr)
				idx_q <= 2'd0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 2'd1;

			if (cmd.emit)
				pend_valid_q <= 1'b1;
			else if (cmd.flush)
				pend_valid_q <= 1'b0;

			if ((cmd.emit || cmd.flush) && pend_valid_q)
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
		end
	end

	assign event_kind = kind_q;
	assign out_byte   = byte_q;
	assign char_final = cf_q;
	assign run_final  = rf_q;
	assign text_final = tf_q;
	assign out_valid  = ovalid_q;

endmodule

// ===== rtl/core/tptok_ctrl.sv =====
// Controller: sequences one item through the datapath, one result per cycle while the output is free.
module tptok_ctrl import tptok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FEED,
		S_CHAR,
		S_END,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t after_pop;

	assign in_stall  = (state_q != S_IDLE);
	assign after_pop = st.qlen_one ? S_END : S_FEED;

	always_comb begin
		cmd     = '0;
		cmd.src = SRC_CLOSE;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_FEED;
				end
			end
			S_FEED: begin
				if (st.out_free) begin
					if (st.pending) begin
						if (st.complete) begin
							if (st.word_open) begin
								cmd.emit     = 1'b1;
								cmd.src      = SRC_CLOSE;
								cmd.clr_word = 1'b1;
							end else begin
								cmd.idx_clr = 1'b1;
								state_d     = S_CHAR;
							end
						end else if (st.last) begin
							cmd.emit     = 1'b1;
							cmd.src      = SRC_UNK;
							cmd.requeue  = 1'b1;
							cmd.clr_held = 1'b1;
						end else begin
							cmd.hold_byte = 1'b1;
							cmd.pop       = 1'b1;
							state_d       = after_pop;
						end
					end else begin
						case (st.head_cls)
							CLS_SPACE: begin
								cmd.emit     = st.word_open;
								cmd.src      = SRC_CLOSE;
								cmd.clr_word = 1'b1;
								cmd.pop      = 1'b1;
								state_d      = after_pop;
							end
							CLS_LEAD: begin
								if (st.last) begin
									cmd.emit = 1'b1;
									cmd.src  = SRC_UNK;
								end else begin
									cmd.start_char = 1'b1;
								end
								cmd.pop = 1'b1;
								state_d = after_pop;
							end
							CLS_BADHI: begin
								cmd.emit = 1'b1;
								cmd.src  = SRC_UNK;
								cmd.pop  = 1'b1;
								state_d  = after_pop;
							end
							CLS_ALNUM: begin
								cmd.emit     = 1'b1;
								cmd.src      = SRC_WORD;
								cmd.set_word = 1'b1;
								cmd.pop      = 1'b1;
								state_d      = after_pop;
							end
							default: begin
								// punctuation closes the word first, then goes out
								cmd.emit = 1'b1;
								if (st.word_open) begin
									cmd.src      = SRC_CLOSE;
									cmd.clr_word = 1'b1;
								end else begin
									cmd.src = SRC_PUNCT;
									cmd.pop = 1'b1;
									state_d = after_pop;
								end
							end
						endcase
					end
				end
			end
			S_CHAR: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.idx_lt) begin
						cmd.src     = SRC_HELD;
						cmd.idx_inc = 1'b1;
					end else begin
						cmd.src      = SRC_LAST;
						cmd.clr_held = 1'b1;
						cmd.pop      = 1'b1;
						state_d      = after_pop;
					end
				end
			end
			S_END: begin
				if (st.out_free) begin
					cmd.emit     = st.eot && st.word_open;
					cmd.src      = SRC_CLOSE;
					cmd.clr_word = st.eot;
					cmd.clr_held = st.eot;
					state_d      = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/core/text_pretokenizer_utf8_top.sv =====
// Top level of the streaming UTF-8 pre-tokeniser.
// Bytes enter one item at a time and leave as token events (word byte, word close,
// single-byte token, multibyte character byte, unknown marker), each with run_final
// on the last event of its byte and text_final on all events of the end-of-text byte.
// Each item passes through accept, examine, end-of-run check and flush of the
// look-ahead slot, and in_stall stays high until the flush is done. A word close
// ahead of a punctuation byte goes out first; a completed character gives its held
// bytes and then the final byte, after a word close when it closes a word. A character
// cut off by end of text gives the unknown marker and then examines the held bytes
// after the lead and the final byte again. The controller drives one event a cycle,
// while the output is free, into a single look-ahead slot so that the last event of
// a run can be flagged.
module text_pretokenizer_utf8_top import tptok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] event_kind,
	output logic [7:0] out_byte,
	output logic       char_final,
	output logic       run_final,
	output logic       text_final
);

	dp_cmd_t    cmd;
	dp_status_t st;

	tptok_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	tptok_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.cmd         (cmd),
		.st          (st),
		.event_kind  (event_kind),
		.out_byte    (out_byte),
		.char_final  (char_final),
		.run_final   (run_final),
		.text_final  (text_final),
		.out_valid   (out_valid),
		.out_stall   (out_stall)
	);

endmodule

// ===== rtl/core/tptok_checker.sv =====
// Port-level checks on the pre-tokeniser outputs, bound to the top level.
module tptok_checker import tptok_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] event_kind,
	input logic [7:0] out_byte,
	input logic       char_final,
	input logic       run_final,
	input logic       text_final
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) &&
			$stable(out_byte) && $stable(run_final) && $stable(text_final))
		else $error("stalled item changed");

	a_cf_only_mb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_final |-> event_kind == KIND_MB)
		else $error("char_final outside a multibyte character");

	a_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == KIND_CLOSE || event_kind == KIND_UNK) |->
			out_byte == 8'h00)
		else $error("close or unknown event carries a byte");

	a_word_lower: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == KIND_WORD |->
			(out_byte >= 8'h30 && out_byte <= 8'h39) ||
			(out_byte >= 8'h61 && out_byte <= 8'h7A))
		else $error("word byte not a lowercase letter or digit");

endmodule

bind text_pretokenizer_utf8_top tptok_checker u_tptok_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_kind (event_kind),
	.out_byte   (out_byte),
	.char_final (char_final),
	.run_final  (run_final),
	.text_final (text_final)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the streaming UTF-8 pre-tokeniser: directed and random byte streams.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tptok_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_EVENTS   = 8;
	localparam int MAX_REPORTS  = 40;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       char_end;
		logic       run_end;
		logic       text_end;
	} tok_event_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] event_kind;
	logic [7:0] out_byte;
	logic       char_final;
	logic       run_final;
	logic       text_final;

	// tokeniser state as predicted
	logic [7:0] held [3];
	logic [1:0] held_n = 2'd0;
	logic [2:0] char_len = 3'd0;
	logic       word_open = 1'b0;

	tok_event_t run_events[$];
	logic [7:0] reparse_q[$];
	tok_event_t expected_events[$];

	bit calm = 1'b0;
	int hold_req = 0;
	int hold_left = 0;
	int cycles = 0;
	int errors = 0;
	int items_sent = 0;
	int texts_sent = 0;
	int events_checked = 0;

	text_pretokenizer_utf8_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.out_byte   (out_byte),
		.char_final (char_final),
		.run_final  (run_final),
		.text_final (text_final)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding", cycles,
				expected_events.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic bit is_blank(input logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic bit is_word_char(input logic [7:0] b);
		return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	task automatic add_event(input logic [2:0] kind, input logic [7:0] data,
			input logic char_end);
		tok_event_t e;
		if (run_events.size() < MAX_EVENTS) begin
			e = '{kind, data, char_end, 1'b0, 1'b0};
			run_events = {run_events, e};
		end
	endtask

	task automatic end_word();
		if (word_open) begin
			add_event(KIND_CLOSE, 8'h00, 1'b0);
			word_open = 1'b0;
		end
	endtask

	task automatic scan_byte(input logic [7:0] b, input bit last);
		logic [2:0] len;
		int k;
		if (char_len != 3'd0) begin
			if ({1'b0, held_n} + 3'd1 >= char_len) begin
				end_word();
				for (k = 0; k < held_n; k++)
					add_event(KIND_MB, held[k], 1'b0);
				add_event(KIND_MB, b, 1'b1);
				held_n = 2'd0;
				char_len = 3'd0;
			end else if (last) begin
				// cut off by end of text: marker, then the bytes after the lead go round again
				add_event(KIND_UNK, 8'h00, 1'b0);
				for (k = 1; k < held_n; k++)
					reparse_q = {reparse_q, held[k]};
				reparse_q = {reparse_q, b};
				held_n = 2'd0;
				char_len = 3'd0;
			end else begin
				held[held_n] = b;
				held_n = held_n + 2'd1;
			end
		end else if (is_blank(b)) begin
			end_word();
		end else if (b[7]) begin
			casez (b)
				8'b110?????: len = 3'd2;
				8'b1110????: len = 3'd3;
				8'b11110???: len = 3'd4;
				default:     len = 3'd0;
			endcase
			if (len == 3'd0 || last) begin
				add_event(KIND_UNK, 8'h00, 1'b0);
			end else begin
				held[0] = b;
				held_n = 2'd1;
				char_len = len;
			end
		end else if (is_word_char(b)) begin
			add_event(KIND_WORD, (b >= "A" && b <= "Z") ? (b | 8'h20) : b, 1'b0);
			word_open = 1'b1;
		end else begin
			end_word();
			add_event(KIND_PUNCT, b, 1'b0);
		end
	endtask

	task automatic tokenise_item(input logic [7:0] b, input logic eot);
		logic [7:0] cur;
		int k;
		run_events.delete();
		reparse_q.delete();
		reparse_q = {reparse_q, b};
		while (reparse_q.size() > 0) begin
			cur = reparse_q.pop_front();
			scan_byte(cur, eot && reparse_q.size() == 0);
		end
		if (eot) begin
			end_word();
			held_n = 2'd0;
			char_len = 3'd0;
		end
		for (k = 0; k < run_events.size(); k++) begin
			run_events[k].run_end = (k == run_events.size() - 1);
			run_events[k].text_end = eot;
			expected_events = {expected_events, run_events[k]};
		end
	endtask

	task automatic report_mismatch(input string what, input tok_event_t got,
			input tok_event_t want);
		errors++;
		if (errors <= MAX_REPORTS)
			$display({"cycle %0d %s: got kind %0d byte %02h cf %b rf %b tf %b,",
				" want kind %0d byte %02h cf %b rf %b tf %b"},
				cycles, what, got.kind, got.data, got.char_end, got.run_end, got.text_end,
				want.kind, want.data, want.char_end, want.run_end, want.text_end);
	endtask

	task automatic send_item(input logic [7:0] b, input logic eot);
		while (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tokenise_item(b, eot);
		items_sent++;
		if (eot)
			texts_sent++;
	endtask

	function automatic logic [7:0] make_lead(input int len);
		case (len)
			2:       return 8'hC0 | 8'($urandom_range(0, 31));
			3:       return 8'hE0 | 8'($urandom_range(0, 15));
			default: return 8'hF0 | 8'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic logic [7:0] make_trail();
		// trailing bytes go unchecked, so now and then anything at all
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	task automatic send_text(input int segs);
		logic [7:0] txt[$];
		logic [7:0] b;
		int s, k, n, pick, len;
		for (s = 0; s < segs; s++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++)
					case ($urandom_range(0, 2))
						0:       txt = {txt, 8'(8'h41 + 8'($urandom_range(0, 25)))};
						1:       txt = {txt, 8'(8'h61 + 8'($urandom_range(0, 25)))};
						default: txt = {txt, 8'(8'h30 + 8'($urandom_range(0, 9)))};
					endcase
			end else if (pick < 60) begin
				b = ($urandom_range(0, 2) == 0) ? 8'h09 + 8'($urandom_range(0, 4)) : 8'h20;
				txt = {txt, b};
			end else if (pick < 75) begin
				do
					b = 8'($urandom_range(0, 127));
				while (is_blank(b) || is_word_char(b));
				txt = {txt, b};
			end else if (pick < 92) begin
				len = $urandom_range(2, 4);
				txt = {txt, make_lead(len)};
				for (k = 1; k < len; k++)
					txt = {txt, make_trail()};
			end else begin
				b = $urandom_range(0, 1) ? 8'h80 | 8'($urandom_range(0, 63))
					: 8'hF8 | 8'($urandom_range(0, 7));
				txt = {txt, b};
			end
		end
		// sometimes the text stops part way through a character
		if ($urandom_range(0, 4) == 0) begin
			len = $urandom_range(2, 4);
			txt = {txt, make_lead(len)};
			n = $urandom_range(0, len - 2);
			for (k = 0; k < n; k++)
				txt = {txt, make_trail()};
		end
		for (k = 0; k < txt.size(); k++)
			send_item(txt[k], k == txt.size() - 1);
	endtask

	task automatic test_directed();
		logic [8:0] seq [25] = '{
			9'h041, 9'h05A, 9'h039, 9'h0FF, 9'h07A, 9'h020, 9'h000, 9'h07F, 9'h071,
			9'h080, 9'h0F8, 9'h0C3, 9'h0A9, 9'h0E2, 9'h020, 9'h041, 9'h0F0, 9'h0E0,
			9'h1C0, 9'h1F7, 9'h162, 9'h009, 9'h00D, 9'h078, 9'h10A
		};
		int k;
		for (k = 0; k < 25; k++)
			send_item(seq[k][7:0], seq[k][8]);
	endtask

	task automatic test_random_text();
		int start;
		start = items_sent;
		while (items_sent - start < 120)
			send_text($urandom_range(1, 8));
	endtask

	task automatic test_streaming();
		int start;
		start = items_sent;
		calm = 1'b1;
		while (items_sent - start < 40)
			send_text($urandom_range(2, 8));
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		int start;
		start = items_sent;
		hold_req = 150;
		while (items_sent - start < 30)
			send_text($urandom_range(2, 6));
	endtask

	task automatic test_noise();
		int k;
		for (k = 0; k < 50; k++)
			send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
	endtask

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 14);
		end
	end

	always @(posedge clk) begin
		tok_event_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{event_kind, out_byte, char_final, run_final, text_final};
			if (expected_events.size() == 0) begin
				report_mismatch("unexpected event", got, got);
			end else begin
				want = expected_events.pop_front();
				events_checked++;
				if (got !== want)
					report_mismatch("event mismatch", got, want);
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_text();
		test_streaming();
		test_backpressure();
		test_noise();
		in_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d bytes over %0d ended texts, %0d token events compared",
			items_sent, texts_sent, events_checked);
		$display("included truncated characters, bad leads, long output hold-off and noise");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
